// ===== hdl/tcap_pkg.sv =====
// Shared types and codes for the change-driven trace capture block.
// No dependencies; imported by every module of the block except tcap_ram.
`default_nettype none

package tcap_pkg;

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_REARM  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_SAMPLE_TYPE  = 3'd1;
  localparam logic [2:0] REG_TRIGGER_MODE = 3'd2;
  localparam logic [2:0] REG_THRESHOLD    = 3'd3;
  localparam logic [2:0] REG_RING_SIZE    = 3'd4;

  localparam logic [2:0] TYPE_S8  = 3'd0;
  localparam logic [2:0] TYPE_S16 = 3'd1;
  localparam logic [2:0] TYPE_S32 = 3'd2;
  localparam logic [2:0] TYPE_U8  = 3'd3;
  localparam logic [2:0] TYPE_U16 = 3'd4;

  localparam logic [10:0] RING_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic               enable;
    logic [2:0]         sample_type;
    logic [1:0]         trigger_mode;
    logic signed [31:0] threshold;
    logic [10:0]        ring_size;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               recorded;
    logic               pop;
    logic [9:0]         fill;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0]        trigger_time;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/tcap_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module tcap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcap_cfg.sv =====
// Configuration register file of the trace capture block.
// Depends on tcap_pkg for register indexes and the cfg_t type.
`default_nettype none

module tcap_cfg import tcap_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b0;
      cfg.sample_type  <= TYPE_S32;
      cfg.trigger_mode <= 2'd0;
      cfg.threshold    <= 32'sd0;
      cfg.ring_size    <= RING_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_SAMPLE_TYPE:  cfg.sample_type  <= cfg_data[2:0];
        REG_TRIGGER_MODE: cfg.trigger_mode <= cfg_data[1:0];
        REG_THRESHOLD:    cfg.threshold    <= $signed(cfg_data);
        REG_RING_SIZE:    cfg.ring_size    <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcap_ring.sv =====
// Ring state, extremes and trigger tracking, plus the entry memory.
// Depends on tcap_pkg and tcap_ram.
`default_nettype none

module tcap_ring import tcap_pkg::*; #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] timestamp,
  input  wire logic [31:0] raw_sample,
  input  wire cfg_t        cfg,
  output res_t             res,
  output logic [63:0]      entry_data
);

  localparam int IW = $clog2(RING_DEPTH);
  localparam int NW = $clog2(RING_DEPTH + 1);
  localparam int FW = (NW + 1 > 10) ? NW + 1 : 10;

  logic [IW-1:0]      wi, ri, wi_next, ri_next, wi0, ri0;
  logic signed [31:0] prev, prev_next, minv, minv_next, maxv, maxv_next;
  logic [31:0]        trig, trig_next;
  logic [NW-1:0]      n;
  logic signed [31:0] val;
  logic [FW-1:0]      fill_w;
  logic               mem_we, mem_re;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i, input logic [NW-1:0] lim);
    logic [NW:0] inc;
    inc = (NW + 1)'(i) + (NW + 1)'(1);
    if (inc >= (NW + 1)'(lim)) begin
      return '0;
    end
    return IW'(inc);
  endfunction

  function automatic logic signed [31:0] extend(input logic [2:0] kind, input logic [31:0] raw);
    case (kind)
      TYPE_S8:  return $signed({{24{raw[7]}}, raw[7:0]});
      TYPE_S16: return $signed({{16{raw[15]}}, raw[15:0]});
      TYPE_U8:  return $signed({24'd0, raw[7:0]});
      TYPE_U16: return $signed({16'd0, raw[15:0]});
      default:  return $signed(raw);
    endcase
  endfunction

  always_comb begin
    if (32'(cfg.ring_size) > 32'(RING_DEPTH)) begin
      n = NW'(RING_DEPTH);
    end else begin
      n = NW'(cfg.ring_size);
    end
  end

  always_comb begin
    if (32'(wi) >= 32'(n) || 32'(ri) >= 32'(n)) begin
      wi0 = '0;
      ri0 = '0;
    end else begin
      wi0 = wi;
      ri0 = ri;
    end
    val          = extend(cfg.sample_type, raw_sample);
    wi_next      = wi0;
    ri_next      = ri0;
    prev_next    = prev;
    minv_next    = minv;
    maxv_next    = maxv;
    trig_next    = trig;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    res.status   = ST_OK;
    res.recorded = 1'b0;
    res.pop      = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (!cfg.enable || n == '0) begin
          res.status = ST_IGNORED;
        end else if (val != prev) begin
          if (cfg.trigger_mode[0] && prev < cfg.threshold && val >= cfg.threshold) begin
            trig_next = timestamp;
          end
          if (cfg.trigger_mode[1] && prev >= cfg.threshold && val < cfg.threshold) begin
            trig_next = timestamp;
          end
          prev_next = val;
          if (minv > val) begin
            minv_next = val;
          end
          if (maxv < val) begin
            maxv_next = val;
          end
          mem_we  = 1'b1;
          wi_next = next_idx(wi0, n);
          if (wi_next == ri0) begin
            ri_next = next_idx(ri0, n);
          end
          res.recorded = 1'b1;
        end else if (wi0 == ri0) begin
          mem_we       = 1'b1;
          wi_next      = next_idx(wi0, n);
          res.recorded = 1'b1;
        end
      end
      CMD_POP: begin
        if (n == '0 || ri0 == wi0) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re  = 1'b1;
          res.pop = 1'b1;
          ri_next = next_idx(ri0, n);
        end
      end
      CMD_CLEAR: begin
        wi_next   = '0;
        ri_next   = '0;
        trig_next = '0;
      end
      default: begin
        wi_next   = '0;
        ri_next   = '0;
        prev_next = '0;
        minv_next = '0;
        maxv_next = '0;
        trig_next = '0;
      end
    endcase
    if (wi_next >= ri_next) begin
      fill_w = FW'(wi_next) - FW'(ri_next);
    end else begin
      fill_w = FW'(n) - FW'(ri_next) + FW'(wi_next);
    end
    res.fill         = fill_w[9:0];
    res.min_value    = minv_next;
    res.max_value    = maxv_next;
    res.trigger_time = trig_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wi   <= '0;
      ri   <= '0;
      prev <= '0;
      minv <= '0;
      maxv <= '0;
      trig <= '0;
    end else if (accept) begin
      wi   <= wi_next;
      ri   <= ri_next;
      prev <= prev_next;
      minv <= minv_next;
      maxv <= maxv_next;
      trig <= trig_next;
    end
  end

  tcap_ram #(
    .WIDTH(64),
    .DEPTH(RING_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && mem_we),
    .waddr(wi0),
    .wdata({timestamp, val}),
    .re   (accept && mem_re),
    .raddr(ri0),
    .rdata(entry_data)
  );

endmodule

`default_nettype wire

// ===== hdl/change_driven_trace_capture_core.sv =====
// Top level of the change-driven trace capture block.
// Result follows in the cycle after acceptance; one per cycle unless the output stalls.
// The state update and the entry memory access happen in the cycle of acceptance.
// A popped entry comes straight from the memory's registered read port.
// Reset (synchronous) clears configuration, indices, extremes and trigger time.
// Entry memory is not cleared; its contents are undefined until written.
`default_nettype none

module change_driven_trace_capture_core import tcap_pkg::*; #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [31:0]        timestamp,
  input  wire logic [31:0]        raw_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic                    recorded,
  output logic [31:0]             entry_time,
  output logic signed [31:0]      entry_value,
  output logic [9:0]              fill_count,
  output logic signed [31:0]      min_value,
  output logic signed [31:0]      max_value,
  output logic [31:0]             trigger_time
);

  cfg_t        cfg;
  res_t        res, res_q;
  logic [63:0] entry_data;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tcap_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tcap_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .timestamp (timestamp),
    .raw_sample(raw_sample),
    .cfg       (cfg),
    .res       (res),
    .entry_data(entry_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign recorded     = res_q.recorded;
  assign entry_time   = res_q.pop ? entry_data[63:32] : 32'd0;
  assign entry_value  = res_q.pop ? $signed(entry_data[31:0]) : 32'sd0;
  assign fill_count   = res_q.fill;
  assign min_value    = res_q.min_value;
  assign max_value    = res_q.max_value;
  assign trigger_time = res_q.trigger_time;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_recorded_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && recorded |-> status == ST_OK)
    else $error("recorded transaction with non-ok status");

  a_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> entry_time == 32'd0 && entry_value == 32'sd0)
    else $error("entry fields set on failed transaction");

  a_rearm_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_REARM |=> min_value == 32'sd0 && max_value == 32'sd0
      && trigger_time == 32'd0 && fill_count == 10'd0)
    else $error("re-arm left state behind");

endmodule

`default_nettype wire

// ===== tb/sv/change_driven_trace_capture_core_tb.sv =====
// Self-checking testbench for change_driven_trace_capture_core.
// Predicts every transaction in a scoreboard class and checks each result in order.
// Depends on tcap_pkg and the RTL of the block only.
module change_driven_trace_capture_core_tb;
  import tcap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_ENTRIES   = 1024;
  localparam int          RANDOM_ITEMS   = 500;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [2:0]  TYPE_SPARE     = 3'd7;
  localparam logic [1:0]  TRIG_OFF       = 2'd0;
  localparam logic [1:0]  TRIG_RISE      = 2'd1;
  localparam logic [1:0]  TRIG_FALL      = 2'd2;
  localparam logic [1:0]  TRIG_BOTH      = 2'd3;

  typedef struct {
    logic [1:0]         status;
    logic               recorded;
    logic [31:0]        entry_time;
    logic signed [31:0] entry_value;
    logic [9:0]         fill;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0]        trigger_time;
  } capture_report_t;

  class capture_predictor;
    logic               enable;
    logic [2:0]         sample_type;
    logic [1:0]         trigger_mode;
    logic signed [31:0] threshold;
    logic [10:0]        ring_size;
    logic [31:0]        stamp_mem [RING_ENTRIES];
    logic [31:0]        value_mem [RING_ENTRIES];
    bit                 written [RING_ENTRIES];
    int unsigned        wr_idx;
    int unsigned        rd_idx;
    logic signed [31:0] prev_value;
    logic signed [31:0] min_seen;
    logic signed [31:0] max_seen;
    logic [31:0]        trig_stamp;
    capture_report_t    expected_reports [$];
    int                 errors;

    function new();
      enable       = 1'b0;
      sample_type  = TYPE_S32;
      trigger_mode = TRIG_OFF;
      threshold    = '0;
      ring_size    = RING_SIZE_RESET;
      wr_idx       = 0;
      rd_idx       = 0;
      prev_value   = '0;
      min_seen     = '0;
      max_seen     = '0;
      trig_stamp   = '0;
      errors       = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_ENABLE:       enable = data[0];
        REG_SAMPLE_TYPE:  sample_type = data[2:0];
        REG_TRIGGER_MODE: trigger_mode = data[1:0];
        REG_THRESHOLD:    threshold = data;
        REG_RING_SIZE:    ring_size = data[10:0];
        default: ;
      endcase
    endfunction

    function int unsigned ring_used();
      return (ring_size > RING_ENTRIES) ? RING_ENTRIES : ring_size;
    endfunction

    function int unsigned advance(int unsigned i, int unsigned n);
      return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function void store(logic [31:0] stamp, logic [31:0] value, int unsigned n);
      stamp_mem[wr_idx] = stamp;
      value_mem[wr_idx] = value;
      written[wr_idx]   = 1'b1;
      wr_idx = advance(wr_idx, n);
    endfunction

    function void take_command(logic [1:0] c, logic [31:0] stamp, logic [31:0] raw);
      capture_report_t    r;
      int unsigned        n;
      int unsigned        fill;
      logic signed [31:0] v;
      r = '{default: '0};
      n = ring_used();
      if (wr_idx >= n || rd_idx >= n) begin
        wr_idx = 0;
        rd_idx = 0;
      end
      case (c)
        CMD_SAMPLE: begin
          if (!enable || n == 0) begin
            r.status = ST_IGNORED;
          end else begin
            case (sample_type)
              TYPE_S8:  v = {{24{raw[7]}}, raw[7:0]};
              TYPE_S16: v = {{16{raw[15]}}, raw[15:0]};
              TYPE_U8:  v = {24'd0, raw[7:0]};
              TYPE_U16: v = {16'd0, raw[15:0]};
              default:  v = raw;
            endcase
            if (v != prev_value) begin
              if (trigger_mode[0] && prev_value < threshold && v >= threshold)
                trig_stamp = stamp;
              if (trigger_mode[1] && prev_value >= threshold && v < threshold)
                trig_stamp = stamp;
              prev_value = v;
              if (v < min_seen) min_seen = v;
              if (v > max_seen) max_seen = v;
              store(stamp, v, n);
              if (wr_idx == rd_idx) rd_idx = advance(rd_idx, n);
              r.recorded = 1'b1;
            end else if (wr_idx == rd_idx) begin
              store(stamp, v, n);
              r.recorded = 1'b1;
            end
          end
        end
        CMD_POP: begin
          if (n == 0 || rd_idx == wr_idx) begin
            r.status = ST_EMPTY;
          end else begin
            r.entry_time  = stamp_mem[rd_idx];
            r.entry_value = value_mem[rd_idx];
            rd_idx = advance(rd_idx, n);
          end
        end
        CMD_CLEAR: begin
          wr_idx     = 0;
          rd_idx     = 0;
          trig_stamp = '0;
        end
        default: begin
          wr_idx     = 0;
          rd_idx     = 0;
          prev_value = '0;
          min_seen   = '0;
          max_seen   = '0;
          trig_stamp = '0;
        end
      endcase
      fill = (wr_idx >= rd_idx) ? wr_idx - rd_idx : n - rd_idx + wr_idx;
      r.fill         = fill[9:0];
      r.min_value    = min_seen;
      r.max_value    = max_seen;
      r.trigger_time = trig_stamp;
      expected_reports.push_back(r);
    endfunction

    function bit differs(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_report(capture_report_t got);
      capture_report_t want;
      bit              bad;
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, actual status %h fill %h",
                 $time, got.status, got.fill);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      bad = differs("status", 32'(want.status), 32'(got.status))
          | differs("recorded", 32'(want.recorded), 32'(got.recorded))
          | differs("entry_time", want.entry_time, got.entry_time)
          | differs("entry_value", want.entry_value, got.entry_value)
          | differs("fill_count", 32'(want.fill), 32'(got.fill))
          | differs("min_value", want.min_value, got.min_value)
          | differs("max_value", want.max_value, got.max_value)
          | differs("trigger_time", want.trigger_time, got.trigger_time);
      if (bad) errors++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         cmd = CMD_SAMPLE;
  logic [31:0]        timestamp = '0;
  logic [31:0]        raw_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic               recorded;
  logic [31:0]        entry_time;
  logic signed [31:0] entry_value;
  logic [9:0]         fill_count;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;
  logic [31:0]        trigger_time;

  capture_predictor pred = new();
  int               quiet_cycles = 0;
  int               rx_mode = 0;
  int               rx_span = 0;
  int unsigned      rx_phase = 0;
  logic [31:0]      corner_raw [10] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h0000_0080, 32'h0000_007F,
                                        32'h0000_8000, 32'h0000_7FFF, 32'h0000_00FF,
                                        32'h0000_FFFF};

  change_driven_trace_capture_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .timestamp(timestamp), .raw_sample(raw_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .recorded(recorded), .entry_time(entry_time),
    .entry_value(entry_value), .fill_count(fill_count),
    .min_value(min_value), .max_value(max_value), .trigger_time(trigger_time)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_span <= $urandom_range(16, 160);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_phase % 3) != 0;
      default: out_ready <= (rx_phase % 24) < 6;
    endcase
    rx_phase <= rx_phase + 1;
  end

  always @(posedge clk) begin
    capture_report_t got;
    if (!rst && out_valid && out_ready) begin
      got.status       = status;
      got.recorded     = recorded;
      got.entry_time   = entry_time;
      got.entry_value  = entry_value;
      got.fill         = fill_count;
      got.min_value    = min_value;
      got.max_value    = max_value;
      got.trigger_time = trigger_time;
      pred.check_report(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [1:0] c, input logic [31:0] ts,
                              input logic [31:0] raw);
    in_valid   <= 1'b1;
    cmd        <= c;
    timestamp  <= ts;
    raw_sample <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred.take_command(c, ts, raw);
  endtask

  task automatic hold_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    pred.set_register(idx, data);
  endtask

  // drain all outstanding results before touching the registers
  task automatic set_config(input logic en, input logic [2:0] typ, input logic [1:0] mode,
                            input logic [31:0] th, input logic [10:0] size);
    in_valid <= 1'b0;
    while (pred.expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_SAMPLE_TYPE, {29'd0, typ});
    write_reg(REG_TRIGGER_MODE, {30'd0, mode});
    write_reg(REG_THRESHOLD, th);
    write_reg(REG_RING_SIZE, {21'd0, size});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          counted;
    int          phase;
    int          burst_left;
    int unsigned n;
    int unsigned r;
    int unsigned w;
    logic [1:0]  c;
    logic [31:0] raw;
    logic [31:0] prev_raw;
    logic        en;
    logic [2:0]  typ;
    logic [1:0]  mode;
    logic [31:0] th;
    logic [10:0] size;
    int          pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(CMD_SAMPLE, 32'd1, 32'd5);
    send_command(CMD_POP, 32'd0, 32'd0);
    set_config(1'b1, TYPE_S32, TRIG_BOTH, 32'd0, 11'd1024);
    send_command(CMD_SAMPLE, 32'd0, 32'd0);
    send_command(CMD_SAMPLE, 32'd2, 32'd0);
    send_command(CMD_SAMPLE, 32'd3, 32'h7FFF_FFFF);
    send_command(CMD_SAMPLE, 32'd4, 32'h8000_0000);
    send_command(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, 32'd6, 32'd1);
    send_command(CMD_POP, 32'd0, 32'd0);
    send_command(CMD_CLEAR, 32'd0, 32'd0);
    send_command(CMD_SAMPLE, 32'd8, 32'd1);
    send_command(CMD_REARM, 32'd0, 32'd0);
    set_config(1'b1, TYPE_S8, TRIG_FALL, 32'hFFFF_FFFF, 11'd1024);
    send_command(CMD_SAMPLE, 32'd10, 32'h0000_0080);
    send_command(CMD_SAMPLE, 32'd11, 32'h0000_007F);
    send_command(CMD_SAMPLE, 32'd12, 32'h0000_00FF);
    send_command(CMD_SAMPLE, 32'd13, 32'h0000_017F);
    send_command(CMD_SAMPLE, 32'd14, 32'h0000_0000);
    send_command(CMD_SAMPLE, 32'd15, 32'h0000_0055);
    // lowered ring size leaves the write index outside the ring
    set_config(1'b1, TYPE_U16, TRIG_RISE, 32'h0000_8000, 11'd4);
    send_command(CMD_SAMPLE, 32'd20, 32'hFFFF_8000);
    send_command(CMD_SAMPLE, 32'd21, 32'h0000_7FFF);
    send_command(CMD_SAMPLE, 32'd22, 32'h0000_FFFF);
    send_command(CMD_SAMPLE, 32'd23, 32'h0000_0001);
    send_command(CMD_POP, 32'd0, 32'd0);
    set_config(1'b1, TYPE_SPARE, TRIG_OFF, 32'h7FFF_FFFF, 11'd1);
    send_command(CMD_SAMPLE, 32'd30, 32'h7FFF_FFFF);
    send_command(CMD_POP, 32'd0, 32'd0);
    set_config(1'b1, TYPE_U8, TRIG_BOTH, 32'h8000_0000, 11'd0);
    send_command(CMD_SAMPLE, 32'd40, 32'h0000_0012);
    send_command(CMD_POP, 32'd0, 32'd0);

    counted    = 0;
    phase      = 0;
    burst_left = 0;
    prev_raw   = '0;
    while (counted < RANDOM_ITEMS) begin
      en   = ($urandom_range(0, 9) != 0);
      typ  = 3'($urandom_range(0, 7));
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       th = 32'h8000_0000;
        1:       th = 32'h7FFF_FFFF;
        2:       th = 32'd0;
        3:       th = $urandom_range(0, 400) - 200;
        default: th = $urandom;
      endcase
      case ($urandom_range(0, 10))
        0:       size = 11'd0;
        1:       size = 11'd1;
        2:       size = 11'd2;
        3:       size = 11'd1024;
        4:       size = 11'd2047;
        10:      size = 11'($urandom_range(17, 1023));
        default: size = 11'($urandom_range(3, 16));
      endcase
      if (phase == 0) size = 11'd2047;
      set_config(en, typ, mode, th, size);
      repeat ($urandom_range(30, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)      c = CMD_SAMPLE;
        else if (pick < 88) c = CMD_POP;
        else if (pick < 94) c = CMD_CLEAR;
        else                c = CMD_REARM;
        // never pop a slot that has not been written since power-up
        if (c == CMD_POP) begin
          n = pred.ring_used();
          r = pred.rd_idx;
          w = pred.wr_idx;
          if (w >= n || r >= n) begin
            r = 0;
            w = 0;
          end
          if (n != 0 && r != w && !pred.written[r]) c = CMD_CLEAR;
        end
        case ($urandom_range(0, 9))
          0, 1, 2: raw = pred.threshold + $urandom_range(0, 4) - 2;
          3, 4:    raw = prev_raw;
          5:       raw = $urandom;
          6:       raw = corner_raw[$urandom_range(0, 9)];
          7:       raw = prev_raw ^ (32'd1 << $urandom_range(0, 31));
          default: raw = $urandom_range(0, 300) - 150;
        endcase
        prev_raw = raw;
        counted++;
        if (burst_left == 0) begin
          hold_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_command(c, $urandom, raw);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pred.expected_reports.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (pred.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tcap_pkg.sv
hdl/tcap_ram.sv
hdl/tcap_cfg.sv
hdl/tcap_ring.sv
hdl/change_driven_trace_capture_core.sv
tb/sv/change_driven_trace_capture_core_tb.sv
